// ===== rtl/cc20_pkg.sv =====
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and round functions for the ChaCha20 stream core.
// ----------------------------------------------------------------------------
`default_nettype none

package cc20_pkg;

  // The four "expand 32-byte k" words; entry 0 ("expa") is listed last.
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_KEY_0_7    = 3'd0,
    REG_KEY_8_15   = 3'd1,
    REG_KEY_16_23  = 3'd2,
    REG_KEY_24_31  = 3'd3,
    REG_NONCE_0_7  = 3'd4,
    REG_NONCE_8_11 = 3'd5,
    REG_INIT_CNT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_in;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } result_t;

  // One queued byte, already classified by the front.
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic [POS_W-1:0] pos;
    logic             new_block;
    logic [31:0]      counter;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FEED
  } back_state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  // One half of a quarter round: the first half rotates by 16 and 12, the
  // second half by 8 and 7.
  function automatic qr_t qr_half(input qr_t q, input logic second);
    qr_t         r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    a = q.a + q.b;
    d = q.d ^ a;
    d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
    c = q.c + d;
    b = q.b ^ c;
    b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/chacha20_stream_cipher_core.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 stream cipher over a byte stream, one keystream byte per byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                          Payload
//   item      in         item_valid / item_ready          item_t (byte, end flag)
//   result    out        result_valid / result_ready      result_t (byte, last)
//   cfg       in         cfg_valid / cfg_ready            cfg_index, cfg_data
//
// Bytes inside a keystream block stream at one per cycle while the output is
// not stalled. The first byte of each 64-byte block (and of each message)
// waits for a fresh block: a load step, 4 * DOUBLE_ROUNDS round steps of the
// four half-quarter-round units and one feed-forward step.
// Reset is synchronous; it clears the configuration registers, the message
// position and all handshake state. The front keeps accepting bytes into a
// four-entry queue while the back end computes a block or the output stalls.
`default_nettype none

module chacha20_stream_cipher_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 item_valid,
  output logic                                      item_ready,
  input  wire cc20_pkg::item_t                      item,
  output logic                                      result_valid,
  input  wire logic                                 result_ready,
  output cc20_pkg::result_t                         result,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [cc20_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cc20_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Configuration registers. Keys and nonce are packed little-endian, so
  // the low 32 bits of each register form the lower-numbered word.
  logic [63:0] key_0_7;
  logic [63:0] key_8_15;
  logic [63:0] key_16_23;
  logic [63:0] key_24_31;
  logic [63:0] nonce_0_7;
  logic [31:0] nonce_8_11;
  logic [31:0] initial_counter;

  logic           push;
  cc20_pkg::job_t push_job;
  logic           queue_full;
  logic           head_valid;
  cc20_pkg::job_t head;
  logic           pop;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_0_7         <= '0;
      key_8_15        <= '0;
      key_16_23       <= '0;
      key_24_31       <= '0;
      nonce_0_7       <= '0;
      nonce_8_11      <= '0;
      initial_counter <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        cc20_pkg::REG_KEY_0_7:    key_0_7         <= cfg_data;
        cc20_pkg::REG_KEY_8_15:   key_8_15        <= cfg_data;
        cc20_pkg::REG_KEY_16_23:  key_16_23       <= cfg_data;
        cc20_pkg::REG_KEY_24_31:  key_24_31       <= cfg_data;
        cc20_pkg::REG_NONCE_0_7:  nonce_0_7       <= cfg_data;
        cc20_pkg::REG_NONCE_8_11: nonce_8_11      <= cfg_data[31:0];
        cc20_pkg::REG_INIT_CNT:   initial_counter <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // The front tags each byte with its block position and, for the first
  // byte of a block, the block counter to use.
  cc20_front u_front (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_ready      (item_ready),
    .item            (item),
    .initial_counter (initial_counter),
    .queue_full      (queue_full),
    .push            (push),
    .push_job        (push_job)
  );

  cc20_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // The back end computes a keystream block when the head byte starts one,
  // then XORs bytes into the output register.
  cc20_back #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .key          ({key_24_31, key_16_23, key_8_15, key_0_7}),
    .nonce        ({nonce_8_11, nonce_0_7}),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== rtl/cc20_front.sv =====
// ----------------------------------------------------------------------------
// cc20_front
// Accepts input bytes, tracks the message position and block counter, and
// tags each byte for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_valid,
  output logic                         item_ready,
  input  wire cc20_pkg::item_t         item,
  input  wire logic [31:0]             initial_counter,
  input  wire logic                    queue_full,
  output logic                         push,
  output cc20_pkg::job_t               push_job
);

  logic [cc20_pkg::POS_W-1:0] pos;
  logic [cc20_pkg::POS_W-1:0] pos_next;
  logic [cc20_pkg::POS_W-1:0] eff_pos;
  logic [31:0]                counter;
  logic [31:0]                counter_next;
  logic [31:0]                eff_counter;
  logic                       msg_start;

  assign item_ready = !queue_full;
  assign push       = item_valid && !queue_full;

  // A message start restarts the position and reloads the counter.
  assign eff_pos     = msg_start ? '0 : pos;
  assign eff_counter = msg_start ? initial_counter : counter;
  assign pos_next    = eff_pos + 1'b1;
  assign counter_next = (pos_next == '0) ? eff_counter + 32'd1 : eff_counter;

  always_comb begin
    push_job.data      = item.data_in;
    push_job.last      = item.end_of_message;
    push_job.pos       = eff_pos;
    push_job.new_block = (eff_pos == '0);
    push_job.counter   = eff_counter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      counter   <= '0;
      msg_start <= 1'b1;
    end else if (push) begin
      counter <= counter_next;
      if (item.end_of_message) begin
        pos       <= '0;
        msg_start <= 1'b1;
      end else begin
        pos       <= pos_next;
        msg_start <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cc20_fifo.sv =====
// ----------------------------------------------------------------------------
// cc20_fifo
// Short queue of classified bytes between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cc20_pkg::job_t push_job,
  output logic                full,
  output logic                head_valid,
  output cc20_pkg::job_t      head,
  input  wire logic           pop
);

  cc20_pkg::job_t                   entries [cc20_pkg::QUEUE_DEPTH];
  logic [cc20_pkg::QPTR_W-1:0]      wr_ptr;
  logic [cc20_pkg::QPTR_W-1:0]      rd_ptr;
  logic [cc20_pkg::QCNT_W-1:0]      count;

  assign full       = (count == cc20_pkg::QCNT_W'(cc20_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cc20_back.sv =====
// ----------------------------------------------------------------------------
// cc20_back
// Keystream block engine and output stage: runs the double rounds as four
// half quarter rounds per cycle and XORs queued bytes with the keystream.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_back #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [255:0]    key,
  input  wire logic [95:0]     nonce,
  input  wire logic            head_valid,
  input  wire cc20_pkg::job_t  head,
  output logic                 pop,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output cc20_pkg::result_t    result
);

  localparam int STEP_W = $clog2(4 * DOUBLE_ROUNDS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(4 * DOUBLE_ROUNDS - 1);

  cc20_pkg::back_state_t state;
  cc20_pkg::back_state_t state_next;
  logic [STEP_W-1:0]     step;
  logic                  block_ready;
  logic [31:0]           blk_counter;
  logic [31:0]           working   [16];
  logic [31:0]           keystream [16];
  logic [31:0]           init_w    [16];
  logic [31:0]           round_w   [16];
  cc20_pkg::qr_t         q_in      [4];
  cc20_pkg::qr_t         q_out     [4];
  logic [3:0]            ia        [4];
  logic [3:0]            ib        [4];
  logic [3:0]            ic        [4];
  logic [3:0]            id        [4];
  logic                  diag;
  logic [31:0]           ks_word;
  logic [7:0]            ks_byte;

  // Block input words; the counter comes from the queue head when a block
  // starts and from the held copy for the final add.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i] = cc20_pkg::SIGMA[i];
    end
    for (int i = 0; i < 8; i++) begin
      init_w[4 + i] = key[32*i +: 32];
    end
    init_w[12] = (state == cc20_pkg::ST_IDLE) ? head.counter : blk_counter;
    init_w[13] = nonce[31:0];
    init_w[14] = nonce[63:32];
    init_w[15] = nonce[95:64];
  end

  // Bit 1 of the step picks column or diagonal, bit 0 picks the half.
  assign diag = step[1];

  always_comb begin
    round_w = working;
    for (int i = 0; i < 4; i++) begin
      ia[i] = {2'b00, 2'(i)};
      ib[i] = {2'b01, diag ? 2'(i + 1) : 2'(i)};
      ic[i] = {2'b10, diag ? 2'(i + 2) : 2'(i)};
      id[i] = {2'b11, diag ? 2'(i + 3) : 2'(i)};
      q_in[i].a = working[ia[i]];
      q_in[i].b = working[ib[i]];
      q_in[i].c = working[ic[i]];
      q_in[i].d = working[id[i]];
      q_out[i] = cc20_pkg::qr_half(q_in[i], step[0]);
    end
    for (int i = 0; i < 4; i++) begin
      round_w[ia[i]] = q_out[i].a;
      round_w[ib[i]] = q_out[i].b;
      round_w[ic[i]] = q_out[i].c;
      round_w[id[i]] = q_out[i].d;
    end
  end

  assign ks_word = keystream[head.pos[5:2]];
  assign ks_byte = ks_word[8*head.pos[1:0] +: 8];

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      cc20_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.new_block && !block_ready) begin
            state_next = cc20_pkg::ST_ROUND;
          end else if (!result_valid || result_ready) begin
            pop = 1'b1;
          end
        end
      end
      cc20_pkg::ST_ROUND: begin
        if (step == LAST_STEP) begin
          state_next = cc20_pkg::ST_FEED;
        end
      end
      cc20_pkg::ST_FEED: begin
        state_next = cc20_pkg::ST_IDLE;
      end
      default: begin
        state_next = cc20_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cc20_pkg::ST_IDLE;
      step         <= '0;
      block_ready  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cc20_pkg::ST_ROUND) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
      if (state == cc20_pkg::ST_FEED) begin
        block_ready <= 1'b1;
      end else if (pop) begin
        block_ready <= 1'b0;
      end
      if (pop) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cc20_pkg::ST_IDLE && state_next == cc20_pkg::ST_ROUND) begin
      blk_counter <= head.counter;
      working     <= init_w;
    end else if (state == cc20_pkg::ST_ROUND) begin
      working <= round_w;
    end
    if (state == cc20_pkg::ST_FEED) begin
      for (int i = 0; i < 16; i++) begin
        keystream[i] <= working[i] + init_w[i];
      end
    end
    if (pop) begin
      result.data_out <= head.data ^ ks_byte;
      result.last_out <= head.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cc20_checker.sv =====
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks for the ChaCha20 stream core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cc20_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire cc20_pkg::result_t result,
  input wire logic              cfg_valid,
  input wire logic              cfg_ready
);

  // Bytes taken in but not yet handed out.
  logic [3:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 4'(item_valid && item_ready)
                                 - 4'(result_valid && result_ready);
    end
  end

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 4'd0)
    else $error("result shown with no byte outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 4'(cc20_pkg::QUEUE_DEPTH + 1))
    else $error("more bytes in flight than the queue and output hold");

  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration transfer refused");

endmodule

bind chacha20_stream_cipher_core cc20_checker u_cc20_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire

// ===== test/chacha20_stream_cipher_core_tb.sv =====
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core_tb
// Self-checking bench for the byte-serial ChaCha20 cipher core. A tracker
// class keeps its own copy of key, nonce, counter and keystream, predicts
// every output byte from the accepted input bytes and compares each result
// transfer field by field. Directed bytes come first, then random messages
// across several key, nonce and counter settings with random stalls.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core_tb;

  localparam int ROUNDS = 10;

  // Index past the last register; the core must ignore writes to it.
  localparam logic [cc20_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // Cycles the receiver keeps ready low when the bench asks for back-pressure.
  localparam int HOLD_CYCLES = 200;

  // The tail wait after the last result covers one keystream block computation
  // plus the queue.
  localparam int DRAIN_CYCLES = 4 * ROUNDS + 20;

  // Longest legal stretch without any transfer is the receiver hold plus one
  // block computation plus a long sender gap; this is several times that.
  localparam int QUIET_LIMIT = 3000;

  // Tracks the cipher state and holds the bytes the core still owes us.
  class cipher_tracker;
    logic [63:0]       regs[7];
    logic [31:0]       mix[16];
    logic [31:0]       stream_words[16];
    logic [5:0]        byte_pos;
    logic [31:0]       blk_ctr;
    bit                fresh_msg;
    cc20_pkg::result_t expected_bytes[$];
    int                errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (stream_words[i]) stream_words[i] = '0;
      byte_pos  = '0;
      blk_ctr   = '0;
      fresh_msg = 1'b1;
      errors    = 0;
    endfunction

    function void write_reg(input logic [cc20_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [63:0] val);
      if (idx > cc20_pkg::REG_INIT_CNT) return;
      if (idx >= cc20_pkg::REG_NONCE_8_11) val[63:32] = '0;
      regs[idx] = val;
    endfunction

    function logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(input int a, input int b, input int c, input int d);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Builds the next 64-byte keystream block from the current settings.
    function void refill();
      logic [31:0] seed_words[16];
      for (int i = 0; i < 4; i++) seed_words[i] = cc20_pkg::SIGMA[i];
      for (int i = 0; i < 8; i++) seed_words[4 + i] = regs[i / 2][32 * (i % 2) +: 32];
      seed_words[12] = blk_ctr;
      seed_words[13] = regs[cc20_pkg::REG_NONCE_0_7][31:0];
      seed_words[14] = regs[cc20_pkg::REG_NONCE_0_7][63:32];
      seed_words[15] = regs[cc20_pkg::REG_NONCE_8_11][31:0];
      mix = seed_words;
      for (int r = 0; r < ROUNDS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) stream_words[i] = mix[i] + seed_words[i];
    endfunction

    function void note_item(input cc20_pkg::item_t it);
      cc20_pkg::result_t want;
      logic [31:0]       word;
      if (fresh_msg) begin
        blk_ctr   = regs[cc20_pkg::REG_INIT_CNT][31:0];
        byte_pos  = '0;
        fresh_msg = 1'b0;
      end
      if (byte_pos == 0) refill();
      word = stream_words[byte_pos[5:2]] >> (8 * byte_pos[1:0]);
      want.data_out = it.data_in ^ word[7:0];
      want.last_out = it.end_of_message;
      expected_bytes.push_back(want);
      byte_pos = byte_pos + 6'd1;
      if (byte_pos == 0) blk_ctr = blk_ctr + 32'd1;
      if (it.end_of_message) begin
        byte_pos  = '0;
        fresh_msg = 1'b1;
      end
    endfunction

    function void check_result(input cc20_pkg::result_t got);
      cc20_pkg::result_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, data_out %h last_out %b",
                 $time, got.data_out, got.last_out);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.data_out !== want.data_out) begin
        errors++;
        $display("%0t: data_out mismatch, expected %h actual %h",
                 $time, want.data_out, got.data_out);
      end
      if (got.last_out !== want.last_out) begin
        errors++;
        $display("%0t: last_out mismatch, expected %b actual %b",
                 $time, want.last_out, got.last_out);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst;
  logic                                 item_valid;
  logic                                 item_ready;
  cc20_pkg::item_t                      item;
  logic                                 result_valid;
  logic                                 result_ready;
  cc20_pkg::result_t                    result;
  logic                                 cfg_valid;
  logic                                 cfg_ready;
  logic [cc20_pkg::CFG_INDEX_W-1:0]     cfg_index;
  logic [cc20_pkg::CFG_DATA_W-1:0]      cfg_data;

  cipher_tracker sb = new();

  // When steady is set neither side inserts idle cycles.
  bit steady = 1'b0;
  // Set by the stimulus to make the receiver hold off for HOLD_CYCLES.
  bit hold_output = 1'b0;
  int quiet_cycles = 0;

  chacha20_stream_cipher_core #(
    .DOUBLE_ROUNDS(ROUNDS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Register values lean toward the extremes so all-zero and all-one keys and
  // nonces show up regularly.
  function automatic logic [63:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Counters near the top of the range make long messages wrap the block
  // counter. The upper half is random since the core must drop it.
  function automatic logic [63:0] pick_count();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return {$urandom, 32'h0000_0000};
    if (r == 1) return {$urandom, 32'hffff_ffff};
    if (r == 2) return {$urandom, 32'hffff_fffe};
    return {$urandom, $urandom};
  endfunction

  // Message lengths: mostly within one keystream block, some spanning a few.
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 40);
    if (r < 95) return $urandom_range(41, 140);
    return $urandom_range(141, 260);
  endfunction

  // Offers one byte after a random gap and waits for its transfer. Valid is
  // only dropped when a gap follows, so back-to-back bytes keep it high.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    cc20_pkg::item_t it;
    int              gap;
    it.data_in        = b;
    it.end_of_message = eom;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_cfg(input logic [cc20_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering bytes and waits until every owed result has come back.
  // Every byte yields a result, so an empty store means the core is idle.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Rewrites a random subset of registers (all of them in the first phase).
  // Phase 1 forces the counter to its top value so the next long message
  // wraps it.
  task automatic reconfigure(input int p);
    bit all_regs;
    all_regs = (p == 0);
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_KEY_0_7, pick_word());
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_KEY_8_15, pick_word());
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_KEY_16_23, pick_word());
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_KEY_24_31, pick_word());
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_NONCE_0_7, pick_word());
    if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_NONCE_8_11, pick_word());
    if (p == 1) write_cfg(cc20_pkg::REG_INIT_CNT, {$urandom, 32'hffff_ffff});
    else if (all_regs || $urandom_range(0, 1)) write_cfg(cc20_pkg::REG_INIT_CNT, pick_count());
    if ($urandom_range(0, 3) == 0) write_cfg(REG_UNUSED, pick_word());
  endtask

  // Receiver: random ready pattern, plus one long hold on request so the
  // four-entry queue fills and the core pushes back on its input.
  initial begin
    int n;
    result_ready = 1'b0;
    forever begin
      if (hold_output) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          result_ready <= 1'b0;
        end
        hold_output = 1'b0;
      end
      n = pick_gap();
      repeat (n) begin
        @(negedge clk);
        result_ready <= 1'b0;
      end
      n = $urandom_range(1, 24);
      repeat (n) begin
        @(negedge clk);
        result_ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest owed byte.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Watchdog: counts cycles in which no channel moves a transfer.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int  bytes_left;
    int  len;
    bit  open_end;
    bit  first_msg;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. First with the all-zero reset key: a four-byte message
    // that ends inside the block, then two single-byte messages.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    drain();

    // All-ones key, nonce and counter, plus a write to the unused index that
    // must leave everything unchanged.
    write_cfg(cc20_pkg::REG_KEY_0_7, '1);
    write_cfg(cc20_pkg::REG_KEY_8_15, '1);
    write_cfg(cc20_pkg::REG_KEY_16_23, '1);
    write_cfg(cc20_pkg::REG_KEY_24_31, '1);
    write_cfg(cc20_pkg::REG_NONCE_0_7, '1);
    write_cfg(cc20_pkg::REG_NONCE_8_11, '1);
    write_cfg(cc20_pkg::REG_INIT_CNT, '1);
    write_cfg(REG_UNUSED, {$urandom, $urandom});
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    drain();

    // The upper halves of the 32-bit registers carry junk the core must drop.
    write_cfg(cc20_pkg::REG_INIT_CNT, {$urandom, 32'h0000_0001});
    write_cfg(cc20_pkg::REG_NONCE_8_11, {$urandom, 32'h0000_0000});
    send_byte(8'h7f, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h3c, 1'b1);
    drain();

    // Random part: twelve phases of random messages. Each phase starts idle
    // with new settings. The last message of a phase is sometimes left open,
    // so the new key takes over at the next block of that same message.
    for (int p = 0; p < 12; p++) begin
      steady = (p % 4 == 3) || (p == 5);
      reconfigure(p);
      if (p == 5) hold_output = 1'b1;
      bytes_left = 64;
      first_msg  = 1'b1;
      while (bytes_left > 0) begin
        len = (p == 1 && first_msg) ? 150 : pick_length();
        first_msg = 1'b0;
        open_end = (len >= bytes_left) && ($urandom_range(0, 2) == 0);
        for (int k = 0; k < len; k++)
          send_byte(8'($urandom_range(0, 255)), (k == len - 1) && !open_end);
        bytes_left = bytes_left - len;
      end
      drain();
    end
    steady = 1'b0;

    // Everything has come back; give the core time to show any extra output.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
